FILE: design/table_driven_packet_deframer_unit_assert.svh
// assertion macros for the packet deframer checker
`ifndef TABLE_DRIVEN_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define TABLE_DRIVEN_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TDPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled in reset
`define TDPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, checked in reset too
`define TDPD_ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: design/tdpd_pkg.sv
// shared types, constants and length table of the packet deframer
`default_nettype none

package tdpd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] LEN_UNUSED   = 16'hFFFF;
    localparam logic [15:0] LEN_VARIABLE = 16'h0000;
    localparam logic [15:0] LEN_SINGLE   = 16'h0001;
    localparam logic [15:0] VAR_MIN_LEN  = 16'h0003;

    typedef enum logic [1:0] {
        ST_PACKET    = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_UNUSED   = 2'd0,
        K_VARIABLE = 2'd1,
        K_SINGLE   = 2'd2,
        K_FIXED    = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]  data;
        t_kind       kind;
        logic [15:0] rem;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [7:0]  packet_id;
        logic        last;
        logic        first;
        logic [7:0]  data;
    } t_result;

    localparam logic [15:0] LEN_ROM [256] = '{
        16'h0068, 16'h0005, 16'h0007, 16'h0000, 16'h0002, 16'h0005, 16'h0005, 16'h0007,
        16'h000e, 16'h0005, 16'h000b, 16'h010a, 16'h0000, 16'h0003, 16'h0000, 16'h003d,
        16'h00d7, 16'h0000, 16'h0000, 16'h000a, 16'h0006, 16'h0009, 16'h0001, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0025, 16'h0000, 16'h0005, 16'h0004, 16'h0008,
        16'h0013, 16'h0008, 16'h0003, 16'h001a, 16'h0007, 16'h0014, 16'h0005, 16'h0002,
        16'h0005, 16'h0001, 16'h0005, 16'h0002, 16'h0002, 16'h0011, 16'h000f, 16'h000a,
        16'h0005, 16'h0001, 16'h0002, 16'h0002, 16'h000a, 16'h028d, 16'h0000, 16'h0008,
        16'h0007, 16'h0009, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0025, 16'h0000,
        16'h00c9, 16'h0000, 16'h0000, 16'h0229, 16'h02c9, 16'h0005, 16'h0000, 16'h000b,
        16'h0049, 16'h005d, 16'h0005, 16'h0009, 16'h0000, 16'h0000, 16'h0006, 16'h0002,
        16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h000c, 16'h0001, 16'h000b, 16'h006e,
        16'h006a, 16'h0000, 16'h0000, 16'h0004, 16'h0002, 16'h0049, 16'h0000, 16'h0031,
        16'h0005, 16'h0009, 16'h000f, 16'h000d, 16'h0001, 16'h0004, 16'h0000, 16'h0015,
        16'h0000, 16'h0000, 16'h0003, 16'h0009, 16'h0013, 16'h0003, 16'h000e, 16'h0000,
        16'h001c, 16'h0000, 16'h0005, 16'h0002, 16'h0000, 16'h0023, 16'h0010, 16'h0011,
        16'h0000, 16'h0009, 16'h0000, 16'h0002, 16'h0000, 16'h000d, 16'h0002, 16'h0000,
        16'h003e, 16'h0000, 16'h0002, 16'h0027, 16'h0045, 16'h0002, 16'h0000, 16'h0000,
        16'h0042, 16'h0000, 16'h0000, 16'h0000, 16'h000b, 16'h0000, 16'h0000, 16'h0000,
        16'h0013, 16'h0041, 16'h0000, 16'h0063, 16'h0000, 16'h0009, 16'h0000, 16'h0002,
        16'h0000, 16'h001a, 16'h0000, 16'h0102, 16'h0135, 16'h0033, 16'h0000, 16'h0000,
        16'h0003, 16'h0009, 16'h0009, 16'h0009, 16'h0095, 16'h0000, 16'h0000, 16'h0004,
        16'h0000, 16'h0000, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h000d,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0040, 16'h0009, 16'h0000,
        16'h0000, 16'h0003, 16'h0006, 16'h0009, 16'h0003, 16'h0000, 16'h0000, 16'h0000,
        16'h0024, 16'h0000, 16'h0000, 16'h0000, 16'h0006, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0002, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
    };

    function automatic t_entry classify(input logic [7:0] b);
        logic [15:0] len;
        t_entry      e;
        len    = LEN_ROM[b];
        e.data = b;
        e.rem  = len - 16'd1;
        if (len == LEN_UNUSED) begin
            e.kind = K_UNUSED;
        end else if (len == LEN_VARIABLE) begin
            e.kind = K_VARIABLE;
        end else if (len == LEN_SINGLE) begin
            e.kind = K_SINGLE;
        end else begin
            e.kind = K_FIXED;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: design/tdpd_front.sv
// front stage: accepts bytes and classifies them by the length table
`default_nettype none

module tdpd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_in_data,
    output logic                 o_push_valid,
    input  wire logic            i_push_ready,
    output tdpd_pkg::t_entry     o_push_entry
);
    import tdpd_pkg::*;

    logic   r_valid;
    t_entry r_entry;

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_entry <= classify(i_in_data);
        end
    end

endmodule

`default_nettype wire

FILE: design/tdpd_queue.sv
// short queue between the classifying front and the framing back
`default_nettype none

module tdpd_queue #(
    parameter int unsigned DEPTH = tdpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire tdpd_pkg::t_entry i_push_entry,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output tdpd_pkg::t_entry      o_pop_entry
);
    import tdpd_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: design/tdpd_back.sv
// back stage: framing state machine and output register
`default_nettype none

module tdpd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_pop_valid,
    output logic                  o_pop_ready,
    input  wire tdpd_pkg::t_entry i_pop_entry,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tdpd_pkg::t_result     o_out
);
    import tdpd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_LEN_LO = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_len_hi, n_len_hi;
    logic        r_out_valid;
    t_result     r_out, n_out;
    logic [15:0] total;
    logic        fire;

    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign fire        = i_pop_valid && o_pop_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign total       = {r_len_hi, i_pop_entry.data};

    always_comb begin
        n_phase      = r_phase;
        n_left       = r_left;
        n_id         = r_id;
        n_len_hi     = r_len_hi;
        n_out.data   = i_pop_entry.data;
        n_out.first  = 1'b0;
        n_out.last   = 1'b0;
        n_out.status = ST_PACKET;
        unique case (r_phase)
            PH_IDLE: begin
                n_id        = i_pop_entry.data;
                n_out.first = 1'b1;
                unique case (i_pop_entry.kind)
                    K_UNUSED: begin
                        n_out.last   = 1'b1;
                        n_out.status = ST_UNKNOWN;
                    end
                    K_VARIABLE: begin
                        n_phase = PH_LEN_HI;
                    end
                    K_SINGLE: begin
                        n_out.last = 1'b1;
                    end
                    K_FIXED: begin
                        n_left  = i_pop_entry.rem;
                        n_phase = PH_BODY;
                    end
                endcase
            end
            PH_LEN_HI: begin
                n_len_hi = i_pop_entry.data;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                priority if (total < VAR_MIN_LEN) begin
                    n_out.last   = 1'b1;
                    n_out.status = ST_MALFORMED;
                    n_phase      = PH_IDLE;
                end else if (total == VAR_MIN_LEN) begin
                    n_out.last = 1'b1;
                    n_left     = '0;
                    n_phase    = PH_IDLE;
                end else begin
                    n_left  = total - VAR_MIN_LEN;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_left <= 16'd1) begin
                    n_left     = '0;
                    n_out.last = 1'b1;
                    n_phase    = PH_IDLE;
                end else begin
                    n_left = r_left - 16'd1;
                end
            end
        endcase
        n_out.packet_id = n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_left      <= '0;
            r_id        <= '0;
            r_len_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase  <= n_phase;
                r_left   <= n_left;
                r_id     <= n_id;
                r_len_hi <= n_len_hi;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: design/table_driven_packet_deframer_unit.sv
// path: a byte goes through the front register, the queue and the back output register
// throughput: one byte per cycle while the master side keeps up, set by the framing state machine
// the queue between front and back absorbs up to QUEUE_DEPTH bytes of output stall
// reset: synchronous active-low i_rst_n empties all stages and returns to waiting for an id
`default_nettype none

module table_driven_packet_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = tdpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,
    output logic [10:0]      m_axis_tuser    // [0] first_of_packet, [8:1] packet_id, [10:9] status
);
    import tdpd_pkg::*;

    logic    push_valid;
    logic    push_ready;
    t_entry  push_entry;
    logic    pop_valid;
    logic    pop_ready;
    t_entry  pop_entry;
    t_result result;

    tdpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    tdpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    tdpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_entry (pop_entry),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (result)
    );

    assign m_axis_tdata = result.data;
    assign m_axis_tlast = result.last;
    assign m_axis_tuser = {result.status, result.packet_id, result.first};

endmodule

`default_nettype wire

FILE: design/tdpd_checker.sv
// port-level checker for the packet deframer, bound to the top level
`default_nettype none

`include "table_driven_packet_deframer_unit_assert.svh"

module tdpd_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,
    input  wire logic        i_m_tlast,
    input  wire logic [10:0] i_m_tuser
);
    import tdpd_pkg::*;

    `TDPD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast) && $stable(i_m_tuser))
    `TDPD_ASSERT_IMP(a_unknown_single, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser[10:9] == ST_UNKNOWN), i_m_tuser[0] && i_m_tlast)
    `TDPD_ASSERT_IMP(a_malformed_ends, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser[10:9] == ST_MALFORMED), i_m_tlast && !i_m_tuser[0])
    `TDPD_ASSERT_NXT_ALL(a_reset_quiet, i_clk, !i_rst_n, !i_m_tvalid)

endmodule

bind table_driven_packet_deframer_unit tdpd_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/sv/tdpd_frame_checker.sv
// frame checker for the packet deframer: predicts each output transfer and compares it
module tdpd_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [7:0] out_byte
    input  logic        i_m_tlast,
    input  logic [10:0] i_m_tuser,   // [0] first_of_packet, [8:1] packet_id, [10:9] status
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tdpd_pkg::*;

    typedef enum logic [1:0] {
        FR_WAIT_ID = 2'd0,
        FR_LEN_HI  = 2'd1,
        FR_LEN_LO  = 2'd2,
        FR_BODY    = 2'd3
    } t_frame_phase;

    t_frame_phase frame_phase;
    logic [15:0]  body_left;
    logic [7:0]   pkt_id;
    logic [7:0]   len_hi_byte;
    t_result      echo_queue[$];

    task automatic frame_byte(input logic [7:0] b, output t_result r);
        logic [15:0] len;
        logic [15:0] total;
        r           = '0;
        r.data      = b;
        r.status    = ST_PACKET;
        case (frame_phase)
            FR_WAIT_ID: begin
                len    = LEN_ROM[b];
                pkt_id = b;
                r.first = 1'b1;
                if (len == LEN_UNUSED) begin
                    r.last   = 1'b1;
                    r.status = ST_UNKNOWN;
                end else if (len == LEN_VARIABLE) begin
                    frame_phase = FR_LEN_HI;
                end else if (len == LEN_SINGLE) begin
                    r.last = 1'b1;
                end else begin
                    body_left   = len - 16'd1;
                    frame_phase = FR_BODY;
                end
            end
            FR_LEN_HI: begin
                len_hi_byte = b;
                frame_phase = FR_LEN_LO;
            end
            FR_LEN_LO: begin
                total = {len_hi_byte, b};
                if (total < VAR_MIN_LEN) begin
                    r.last      = 1'b1;
                    r.status    = ST_MALFORMED;
                    frame_phase = FR_WAIT_ID;
                end else if (total == VAR_MIN_LEN) begin
                    r.last      = 1'b1;
                    body_left   = '0;
                    frame_phase = FR_WAIT_ID;
                end else begin
                    body_left   = total - VAR_MIN_LEN;
                    frame_phase = FR_BODY;
                end
            end
            default: begin
                if (body_left <= 16'd1) begin
                    body_left   = '0;
                    r.last      = 1'b1;
                    frame_phase = FR_WAIT_ID;
                end else begin
                    body_left = body_left - 16'd1;
                end
            end
        endcase
        r.packet_id = pkt_id;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        frame_phase  = FR_WAIT_ID;
        body_left    = '0;
        pkt_id       = '0;
        len_hi_byte  = '0;
    end

    always @(posedge i_clk) begin : track
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            frame_phase = FR_WAIT_ID;
            body_left   = '0;
            pkt_id      = '0;
            len_hi_byte = '0;
            echo_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.data      = i_m_tdata;
                got.first     = i_m_tuser[0];
                got.last      = i_m_tlast;
                got.packet_id = i_m_tuser[8:1];
                got.status    = t_status'(i_m_tuser[10:9]);
                if (echo_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected transfer at %0t: byte %02h", $time, got.data);
                    o_fail_count++;
                end else begin
                    want = echo_queue.pop_front();
                    if (got.data !== want.data || got.first !== want.first ||
                        got.last !== want.last || got.packet_id !== want.packet_id ||
                        got.status !== want.status) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch at %0t: expected byte %02h first %0b last %0b id %02h status %0d",
                                     $time, want.data, want.first, want.last, want.packet_id,
                                     want.status);
                            $display("                got byte %02h first %0b last %0b id %02h status %0d",
                                     got.data, got.first, got.last, got.packet_id, got.status);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                frame_byte(i_s_tdata, want);
                echo_queue.push_back(want);
            end
        end
        o_pending = echo_queue.size();
    end

endmodule

FILE: tb/sv/tb_table_driven_packet_deframer_unit.sv
// testbench top for the packet deframer: clock, reset, byte stream stimulus and verdict
module tb_table_driven_packet_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tdpd_pkg::*;

    localparam int N_ITEMS        = 1900;
    localparam int TAIL_ITEMS     = 300;
    localparam int STALL_AT       = 400;
    localparam int STALL_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int SHORT_LEN      = 40;

    // directed opening: unknown ids, single byte, shortest fixed, malformed and edge lengths
    localparam logic [7:0] OPENING [24] = '{
        8'hFF,                              // unknown id at top of range
        8'h16,                              // single-byte id, length of one
        8'h04, 8'hFF,                       // fixed length two
        8'h03, 8'h00, 8'h00,                // variable length zero
        8'h03, 8'h00, 8'h02,                // variable length two
        8'h03, 8'h00, 8'h03,                // variable length exactly three
        8'h03, 8'h00, 8'h05, 8'hAA, 8'h55,  // variable length five
        8'hC8, 8'h00,                       // last known id
        8'h0D, 8'h01, 8'h80,                // fixed length three
        8'hC5                               // first unknown id
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [7:0] out_byte
    logic        m_axis_tlast;
    logic [10:0] m_axis_tuser;    // [0] first_of_packet, [8:1] packet_id, [10:9] status

    int fail_count;
    int pending;
    int sent_count;
    bit quiet_tail;
    int long_left;

    table_driven_packet_deframer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    tdpd_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        sent_count    = 0;
        quiet_tail    = 1'b0;
        long_left     = 2;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // offer one byte, possibly after a random gap, and return at the negedge after the transfer
    task automatic push_byte(input logic [7:0] b);
        int  gap;
        bit  idle_ok;
        idle_ok = !quiet_tail && ((sent_count / 170) % 4 != 3);
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
        if (sent_count >= N_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] draw_id(input t_kind want, input bit allow_long);
        logic [7:0]  id;
        logic [15:0] len;
        bit          ok;
        ok = 1'b0;
        id = '0;
        while (!ok) begin
            id  = 8'($urandom_range(0, 255));
            len = LEN_ROM[id];
            case (want)
                K_UNUSED:   ok = (len == LEN_UNUSED);
                K_VARIABLE: ok = (len == LEN_VARIABLE);
                K_SINGLE:   ok = (len == LEN_SINGLE);
                default:    ok = (len != LEN_UNUSED) && (len != LEN_VARIABLE) &&
                                 (len != LEN_SINGLE) && (allow_long || len <= SHORT_LEN);
            endcase
        end
        return id;
    endfunction

    task automatic send_packet();
        int          pick;
        bit          go_long;
        logic [7:0]  id;
        logic [15:0] total;
        pick    = $urandom_range(0, 99);
        go_long = (long_left > 0) && ($urandom_range(0, 59) == 0);
        if (pick < 8) begin
            push_byte(draw_id(K_UNUSED, 1'b0));
        end else if (pick < 14) begin
            // variable packet whose length is too short
            push_byte(draw_id(K_VARIABLE, 1'b0));
            push_byte(8'h00);
            push_byte(8'($urandom_range(0, 2)));
        end else if (pick < 20) begin
            push_byte(draw_id(K_SINGLE, 1'b0));
        end else if (pick < 50) begin
            id = draw_id(K_VARIABLE, 1'b0);
            if (go_long) begin
                long_left--;
                total = 16'($urandom_range(256, 700));
            end else begin
                total = 16'($urandom_range(3, 24));
            end
            push_byte(id);
            push_byte(total[15:8]);
            push_byte(total[7:0]);
            for (int i = 3; i < total; i++) push_byte(8'($urandom_range(0, 255)));
        end else begin
            if (go_long) long_left--;
            id    = draw_id(K_FIXED, go_long);
            total = LEN_ROM[id];
            push_byte(id);
            for (int i = 1; i < total; i++) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : source
        @(posedge i_rst_n);
        @(negedge i_clk);
        foreach (OPENING[i]) push_byte(OPENING[i]);
        while (sent_count < N_ITEMS) send_packet();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("table_driven_packet_deframer_unit test passed");
        end else begin
            $display("table_driven_packet_deframer_unit test failed");
        end
        $finish;
    end

    // receiver: random back-pressure bursts plus one long hold-off to fill the block
    initial begin : sink
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == STALL_AT) begin
                hold = STALL_CYCLES;
            end else if (hold == 0 && !quiet_tail && ((cyc / 150) % 3 != 1) &&
                         $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 9);
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("table_driven_packet_deframer_unit test failed");
        $finish;
    end

endmodule

FILE: table_driven_packet_deframer_unit.f
+incdir+design
design/tdpd_pkg.sv
design/tdpd_front.sv
design/tdpd_queue.sv
design/tdpd_back.sv
design/table_driven_packet_deframer_unit.sv
design/tdpd_checker.sv
tb/sv/tdpd_frame_checker.sv
tb/sv/tb_table_driven_packet_deframer_unit.sv
